### hw/rtl/qmi_tlv_pkg.sv
// ----------------------------------------------------------------------------
// QMI TLV message parser package
// Shared types, field layouts and protocol constants for the parser.
// ----------------------------------------------------------------------------
package qmi_tlv_pkg;

    // Longest datagram that is parsed; later bytes are dropped
    localparam int MAX_DATAGRAM = 4096;
    localparam int CNT_W        = $clog2(MAX_DATAGRAM + 1);
    // Wide enough for byte position + 1 + 16-bit record length
    localparam int SUM_W        = ((CNT_W > 16) ? CNT_W : 16) + 2;

    localparam int HDR_LEN      = 7;

    localparam logic [15:0] MSG_REGISTER   = 16'h0020;
    localparam logic [15:0] MSG_INDICATION = 16'h0022;
    localparam logic [15:0] MSG_ACK        = 16'h0023;

    localparam logic [7:0]  MTYPE_RESPONSE   = 8'h02;
    localparam logic [7:0]  MTYPE_INDICATION = 8'h04;

    localparam logic [7:0]  REC_RESULT     = 8'h02;
    localparam logic [7:0]  REC_IND_NAME   = 8'h02;
    localparam logic [7:0]  REC_RESP_STATE = 8'h10;
    localparam logic [7:0]  REC_IND_TXN    = 8'h03;
    localparam logic [7:0]  REC_IND_STATE  = 8'h01;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_TXN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TXN      = CFG_IDX_W'(1);

    localparam logic [15:0] REGISTER_TXN_RST = 16'd1;
    localparam logic [15:0] ACK_TXN_RST      = 16'd2;

    typedef enum logic [1:0] {
        KIND_OTHER    = 2'd0,
        KIND_REGISTER = 2'd1,
        KIND_IND      = 2'd2,
        KIND_ACK      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_COMPLETE  = 2'd0,
        STATUS_SHORT_HDR = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN0  = 2'd1,
        PH_LEN1  = 2'd2,
        PH_VALUE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        t_status     parse_status;
        logic        success;
        logic        result_seen;
        logic [15:0] qmi_result_code;
        logic [15:0] qmi_error_code;
        logic        state_seen;
        logic [31:0] state_value;
        logic        ind_txn_seen;
        logic [15:0] ind_txn;
        logic [15:0] header_txn;
        logic [15:0] header_msg_id;
    } t_out_item;

endpackage

### hw/rtl/qmi_tlv_message_parser.sv
// ----------------------------------------------------------------------------
// QMI TLV message parser
// Streams one datagram a byte at a time and reports one summary per datagram.
// ----------------------------------------------------------------------------
// Usage: feed the datagram one byte per transaction on the input channel, with
// last_byte set on its final byte. A new byte is accepted every cycle while no
// summary waits unaccepted; every byte updates the header, record-walk and capture
// registers in a single pass. The byte marked last produces one summary in
// the output register on the following cycle. While a summary waits there
// unaccepted the input is held off, so an output stall also stalls the bytes.
// Configuration writes are accepted at any time; the transaction ids in force
// when the seventh byte of a datagram arrives decide its kind. Bytes beyond
// qmi_tlv_pkg::MAX_DATAGRAM are dropped.
module qmi_tlv_message_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  qmi_tlv_pkg::t_in_item              i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output qmi_tlv_pkg::t_out_item             o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [qmi_tlv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    localparam int CW = qmi_tlv_pkg::CNT_W;
    localparam int SW = qmi_tlv_pkg::SUM_W;

    logic [15:0] r_cfg_reg_txn;
    logic [15:0] r_cfg_ack_txn;

    logic [CW-1:0]        r_count,    n_count;
    logic [7:0]           r_hdr_type, n_hdr_type;
    logic [15:0]          r_hdr_txn,  n_hdr_txn;
    logic [15:0]          r_hdr_msg,  n_hdr_msg;
    logic [15:0]          r_hdr_len,  n_hdr_len;
    qmi_tlv_pkg::t_kind   r_kind,     n_kind;
    qmi_tlv_pkg::t_phase  r_phase,    n_phase;
    logic [7:0]           r_rec_type, n_rec_type;
    logic [15:0]          r_rec_len,  n_rec_len;
    logic [15:0]          r_rec_off,  n_rec_off;
    logic [31:0]          r_vshift,   n_vshift;
    logic                 r_f_result, n_f_result;
    logic                 r_f_state,  n_f_state;
    logic                 r_f_name,   n_f_name;
    logic                 r_f_txn,    n_f_txn;
    logic                 r_f_trunc,  n_f_trunc;
    logic [15:0]          r_res_code, n_res_code;
    logic [15:0]          r_err_code, n_err_code;
    logic [31:0]          r_state_val, n_state_val;
    logic [15:0]          r_ind_txn,  n_ind_txn;

    logic                    r_out_valid;
    qmi_tlv_pkg::t_out_item  r_out, n_out;

    logic        in_acc;
    logic [7:0]  b;
    logic        fin;
    logic [15:0] fin_len;
    logic [SW-1:0] limit;
    logic [SW-1:0] rec_end;
    logic        trunc;
    logic        hdr_ok;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign b           = i_in_data.data_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign limit   = SW'(qmi_tlv_pkg::HDR_LEN) + SW'(r_hdr_len);
    assign rec_end = SW'(r_count) + SW'(1) + SW'({b, r_rec_len[7:0]});

    // Byte update, record walk and capture
    always_comb begin
        n_count     = r_count;
        n_hdr_type  = r_hdr_type;
        n_hdr_txn   = r_hdr_txn;
        n_hdr_msg   = r_hdr_msg;
        n_hdr_len   = r_hdr_len;
        n_kind      = r_kind;
        n_phase     = r_phase;
        n_rec_type  = r_rec_type;
        n_rec_len   = r_rec_len;
        n_rec_off   = r_rec_off;
        n_vshift    = r_vshift;
        n_f_result  = r_f_result;
        n_f_state   = r_f_state;
        n_f_name    = r_f_name;
        n_f_txn     = r_f_txn;
        n_f_trunc   = r_f_trunc;
        n_res_code  = r_res_code;
        n_err_code  = r_err_code;
        n_state_val = r_state_val;
        n_ind_txn   = r_ind_txn;
        fin         = 1'b0;
        fin_len     = r_rec_len;

        if (in_acc && (r_count < CW'(qmi_tlv_pkg::MAX_DATAGRAM))) begin
            if (r_count < CW'(qmi_tlv_pkg::HDR_LEN)) begin
                case (r_count[2:0])
                    3'd0: n_hdr_type      = b;
                    3'd1: n_hdr_txn[7:0]  = b;
                    3'd2: n_hdr_txn[15:8] = b;
                    3'd3: n_hdr_msg[7:0]  = b;
                    3'd4: n_hdr_msg[15:8] = b;
                    3'd5: n_hdr_len[7:0]  = b;
                    3'd6: begin
                        n_hdr_len[15:8] = b;
                        // Classify on the registers as they stand now
                        if (r_hdr_type == qmi_tlv_pkg::MTYPE_RESPONSE &&
                            r_hdr_txn == r_cfg_reg_txn &&
                            r_hdr_msg == qmi_tlv_pkg::MSG_REGISTER) begin
                            n_kind = qmi_tlv_pkg::KIND_REGISTER;
                        end else if (r_hdr_type == qmi_tlv_pkg::MTYPE_INDICATION &&
                                     r_hdr_msg == qmi_tlv_pkg::MSG_INDICATION) begin
                            n_kind = qmi_tlv_pkg::KIND_IND;
                        end else if (r_hdr_type == qmi_tlv_pkg::MTYPE_RESPONSE &&
                                     r_hdr_txn == r_cfg_ack_txn &&
                                     r_hdr_msg == qmi_tlv_pkg::MSG_ACK) begin
                            n_kind = qmi_tlv_pkg::KIND_ACK;
                        end else begin
                            n_kind = qmi_tlv_pkg::KIND_OTHER;
                        end
                    end
                    default: ;
                endcase
            end else if (!r_f_trunc && (SW'(r_count) < limit)) begin
                case (r_phase)
                    qmi_tlv_pkg::PH_TYPE: begin
                        n_rec_type = b;
                        n_rec_len  = 16'd0;
                        n_phase    = qmi_tlv_pkg::PH_LEN0;
                    end
                    qmi_tlv_pkg::PH_LEN0: begin
                        n_rec_len = {8'd0, b};
                        n_phase   = qmi_tlv_pkg::PH_LEN1;
                    end
                    qmi_tlv_pkg::PH_LEN1: begin
                        n_rec_len = {b, r_rec_len[7:0]};
                        n_rec_off = 16'd0;
                        n_vshift  = 32'd0;
                        fin_len   = {b, r_rec_len[7:0]};
                        if (rec_end > limit) begin
                            n_f_trunc = 1'b1;
                            n_phase   = qmi_tlv_pkg::PH_TYPE;
                        end else if (fin_len == 16'd0) begin
                            fin     = 1'b1;
                            n_phase = qmi_tlv_pkg::PH_TYPE;
                        end else begin
                            n_phase = qmi_tlv_pkg::PH_VALUE;
                        end
                    end
                    default: begin
                        if (r_rec_off < 16'd4) begin
                            n_vshift = r_vshift | (32'(b) << {r_rec_off[1:0], 3'b000});
                        end
                        n_rec_off = r_rec_off + 16'd1;
                        if (n_rec_off == r_rec_len) begin
                            fin     = 1'b1;
                            n_phase = qmi_tlv_pkg::PH_TYPE;
                        end
                    end
                endcase
            end
            n_count = r_count + CW'(1);
        end

        // Capture a completed record by message kind
        if (fin) begin
            case (r_kind)
                qmi_tlv_pkg::KIND_REGISTER: begin
                    if (r_rec_type == qmi_tlv_pkg::REC_RESULT && fin_len >= 16'd4) begin
                        n_res_code = n_vshift[15:0];
                        n_err_code = n_vshift[31:16];
                        n_f_result = 1'b1;
                    end else if (r_rec_type == qmi_tlv_pkg::REC_RESP_STATE &&
                                 fin_len >= 16'd4) begin
                        n_state_val = n_vshift;
                        n_f_state   = 1'b1;
                    end
                end
                qmi_tlv_pkg::KIND_IND: begin
                    if (r_rec_type == qmi_tlv_pkg::REC_IND_STATE && fin_len >= 16'd4) begin
                        n_state_val = n_vshift;
                        n_f_state   = 1'b1;
                    end else if (r_rec_type == qmi_tlv_pkg::REC_IND_NAME) begin
                        n_f_name = 1'b1;
                    end else if (r_rec_type == qmi_tlv_pkg::REC_IND_TXN &&
                                 fin_len >= 16'd2) begin
                        n_ind_txn = n_vshift[15:0];
                        n_f_txn   = 1'b1;
                    end
                end
                qmi_tlv_pkg::KIND_ACK: begin
                    if (r_rec_type == qmi_tlv_pkg::REC_RESULT && fin_len >= 16'd4) begin
                        n_res_code = n_vshift[15:0];
                        n_err_code = n_vshift[31:16];
                        n_f_result = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Summary for the datagram, built from the updated state
    assign hdr_ok = (n_count >= CW'(qmi_tlv_pkg::HDR_LEN));
    assign trunc  = n_f_trunc || (n_phase == qmi_tlv_pkg::PH_VALUE);

    always_comb begin
        n_out                 = '0;
        n_out.kind            = qmi_tlv_pkg::KIND_OTHER;
        n_out.parse_status    = qmi_tlv_pkg::STATUS_SHORT_HDR;
        n_out.qmi_result_code = 16'hFFFF;
        n_out.qmi_error_code  = 16'hFFFF;
        if (hdr_ok) begin
            n_out.kind          = n_kind;
            n_out.parse_status  = trunc ? qmi_tlv_pkg::STATUS_TRUNCATED
                                        : qmi_tlv_pkg::STATUS_COMPLETE;
            n_out.header_txn    = n_hdr_txn;
            n_out.header_msg_id = n_hdr_msg;
            case (n_kind)
                qmi_tlv_pkg::KIND_REGISTER, qmi_tlv_pkg::KIND_ACK: begin
                    n_out.result_seen = n_f_result;
                    if (n_f_result) begin
                        n_out.qmi_result_code = n_res_code;
                        n_out.qmi_error_code  = n_err_code;
                    end
                    n_out.success = n_f_result && (n_res_code == 16'd0);
                    if (n_kind == qmi_tlv_pkg::KIND_REGISTER) begin
                        n_out.state_seen = n_f_state;
                        if (n_f_state) begin
                            n_out.state_value = n_state_val;
                        end
                        if (trunc) begin
                            n_out.success = 1'b0;
                        end
                    end
                end
                qmi_tlv_pkg::KIND_IND: begin
                    n_out.state_seen   = n_f_state;
                    n_out.ind_txn_seen = n_f_txn;
                    if (n_f_state) begin
                        n_out.state_value = n_state_val;
                    end
                    if (n_f_txn) begin
                        n_out.ind_txn = n_ind_txn;
                    end
                    n_out.success = n_f_state && n_f_txn && n_f_name && !trunc;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_reg_txn <= qmi_tlv_pkg::REGISTER_TXN_RST;
            r_cfg_ack_txn <= qmi_tlv_pkg::ACK_TXN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == qmi_tlv_pkg::CFG_REGISTER_TXN) begin
                r_cfg_reg_txn <= i_cfg_data;
            end else if (i_cfg_index == qmi_tlv_pkg::CFG_ACK_TXN) begin
                r_cfg_ack_txn <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in_data.last_byte)) begin
            // Drop all datagram state after reset and after each summary
            r_count     <= '0;
            r_hdr_type  <= '0;
            r_hdr_txn   <= '0;
            r_hdr_msg   <= '0;
            r_hdr_len   <= '0;
            r_kind      <= qmi_tlv_pkg::KIND_OTHER;
            r_phase     <= qmi_tlv_pkg::PH_TYPE;
            r_rec_type  <= '0;
            r_rec_len   <= '0;
            r_rec_off   <= '0;
            r_vshift    <= '0;
            r_f_result  <= 1'b0;
            r_f_state   <= 1'b0;
            r_f_name    <= 1'b0;
            r_f_txn     <= 1'b0;
            r_f_trunc   <= 1'b0;
            r_res_code  <= 16'hFFFF;
            r_err_code  <= 16'hFFFF;
            r_state_val <= '0;
            r_ind_txn   <= '0;
        end else begin
            r_count     <= n_count;
            r_hdr_type  <= n_hdr_type;
            r_hdr_txn   <= n_hdr_txn;
            r_hdr_msg   <= n_hdr_msg;
            r_hdr_len   <= n_hdr_len;
            r_kind      <= n_kind;
            r_phase     <= n_phase;
            r_rec_type  <= n_rec_type;
            r_rec_len   <= n_rec_len;
            r_rec_off   <= n_rec_off;
            r_vshift    <= n_vshift;
            r_f_result  <= n_f_result;
            r_f_state   <= n_f_state;
            r_f_name    <= n_f_name;
            r_f_txn     <= n_f_txn;
            r_f_trunc   <= n_f_trunc;
            r_res_code  <= n_res_code;
            r_err_code  <= n_err_code;
            r_state_val <= n_state_val;
            r_ind_txn   <= n_ind_txn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last_byte) begin
            r_out <= n_out;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(qmi_tlv_pkg::MAX_DATAGRAM))
        else $error("byte count past maximum datagram length");

    a_trunc_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_trunc || r_phase != qmi_tlv_pkg::PH_TYPE) |->
            r_count > CW'(qmi_tlv_pkg::HDR_LEN))
        else $error("record walk active before header complete");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last_byte) |=> (r_count == '0 && !r_f_trunc))
        else $error("datagram state not cleared after last byte");

    a_short_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.parse_status == qmi_tlv_pkg::STATUS_SHORT_HDR) |->
            (r_out.kind == qmi_tlv_pkg::KIND_OTHER && !r_out.success))
        else $error("short header summary carries a message kind");

    a_ind_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == qmi_tlv_pkg::KIND_IND && r_out.success) |->
            (r_out.state_seen && r_out.ind_txn_seen))
        else $error("indication valid without state and transaction records");

endmodule
